/* rtl/jse_pkg.sv */
// ----------------------------------------------------------------------------
// jse_pkg: shared types and escape table
// Packet format between the front end and the byte serializer, and the
// lookup of a decoded character value into its escape text.
// ----------------------------------------------------------------------------
package jse_pkg;

   localparam int MaxBytes   = 6;
   localparam int QueueDepth = 4;
   localparam int PtrWidth   = $clog2(QueueDepth);
   localparam int CountWidth = $clog2(QueueDepth + 1);
   localparam int LenWidth   = $clog2(MaxBytes + 1);

   localparam logic [7:0] CharBsl = 8'h5C;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      byte_type [MaxBytes-1:0] bytes;  // bytes[0] goes out first
      logic [LenWidth-1:0]     len;
      logic                    last;
   } pkt_type;

   typedef struct packed {
      logic                    hit;
      logic [LenWidth-1:0]     len;
      byte_type [MaxBytes-1:0] text;
   } esc_type;

   function automatic esc_type make_esc(input logic [LenWidth-1:0] n,
                                        input byte_type c0, input byte_type c1,
                                        input byte_type c2, input byte_type c3,
                                        input byte_type c4, input byte_type c5);
      esc_type e;
      e.hit     = 1'b1;
      e.len     = n;
      e.text[0] = c0;
      e.text[1] = c1;
      e.text[2] = c2;
      e.text[3] = c3;
      e.text[4] = c4;
      e.text[5] = c5;
      return e;
   endfunction

   function automatic esc_type esc_lookup(input logic [15:0] v);
      esc_type e;
      e = '0;
      unique case (v)
         16'h0000: e = make_esc(3'd4, CharBsl, "x", "0", "0", 8'h00, 8'h00);
         16'h0022: e = make_esc(3'd4, CharBsl, "x", "2", "2", 8'h00, 8'h00);
         16'h0027: e = make_esc(3'd4, CharBsl, "x", "2", "7", 8'h00, 8'h00);
         16'h005C: e = make_esc(3'd2, CharBsl, CharBsl, 8'h00, 8'h00, 8'h00, 8'h00);
         16'h0009: e = make_esc(3'd2, CharBsl, "t", 8'h00, 8'h00, 8'h00, 8'h00);
         16'h000D: e = make_esc(3'd2, CharBsl, "r", 8'h00, 8'h00, 8'h00, 8'h00);
         16'h000A: e = make_esc(3'd2, CharBsl, "n", 8'h00, 8'h00, 8'h00, 8'h00);
         16'h0008: e = make_esc(3'd2, CharBsl, "b", 8'h00, 8'h00, 8'h00, 8'h00);
         16'h000B: e = make_esc(3'd4, CharBsl, "x", "0", "b", 8'h00, 8'h00);
         16'h0026: e = make_esc(3'd4, CharBsl, "x", "2", "6", 8'h00, 8'h00);
         16'h003C: e = make_esc(3'd4, CharBsl, "x", "3", "c", 8'h00, 8'h00);
         16'h003E: e = make_esc(3'd4, CharBsl, "x", "3", "e", 8'h00, 8'h00);
         16'h003D: e = make_esc(3'd4, CharBsl, "x", "3", "d", 8'h00, 8'h00);
         16'h2028: e = make_esc(3'd6, CharBsl, "u", "2", "0", "2", "8");
         16'h2029: e = make_esc(3'd6, CharBsl, "u", "2", "0", "2", "9");
         default:  e = '0;
      endcase
      return e;
   endfunction

endpackage

/* rtl/jse_front.sv */
// ----------------------------------------------------------------------------
// jse_front: UTF-8 sequence tracker and packet builder
// Holds lead and continuation bytes, decodes complete sequences, and builds
// at most one packet of output bytes per accepted input transaction.
// ----------------------------------------------------------------------------
module jse_front
   import jse_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_accept,
   input  byte_type  in_byte,
   input  logic      in_last,
   output logic      pkt_push,
   output pkt_type   pkt
);

   byte_type   held_lead_ff, held_lead_in;
   byte_type   held_second_ff, held_second_in;
   logic [1:0] seq_length_ff, seq_length_in;
   logic [1:0] held_count_ff, held_count_in;

   byte_type [1:0]          pre;
   logic [1:0]              pre_len;
   byte_type [MaxBytes-1:0] tail;
   logic [LenWidth-1:0]     tail_len;
   logic [LenWidth-1:0]     tidx;
   logic                    pending, two_held, is_cont, starts2, starts3;
   logic [15:0]             value;
   esc_type                 esc_b, esc_v;

   always_comb begin
      held_lead_in   = held_lead_ff;
      held_second_in = held_second_ff;
      seq_length_in  = seq_length_ff;
      held_count_in  = held_count_ff;
      pre            = '0;
      pre_len        = '0;
      tail           = '0;
      tail_len       = '0;

      pending  = (seq_length_ff == 2'd2) || (seq_length_ff == 2'd3);
      two_held = (seq_length_ff == 2'd3) && (held_count_ff == 2'd2);
      is_cont  = (in_byte[7:6] == 2'b10);
      starts2  = (in_byte[7:5] == 3'b110);
      starts3  = (in_byte[7:4] == 4'hE);
      esc_b    = esc_lookup({8'h00, in_byte});

      if (seq_length_ff == 2'd2)
         value = {5'd0, held_lead_ff[4:0], in_byte[5:0]};
      else
         value = {held_lead_ff[3:0], held_second_ff[5:0], in_byte[5:0]};
      esc_v = esc_lookup(value);

      if (pending && is_cont) begin
         if ((seq_length_ff == 2'd2) || two_held) begin
            held_lead_in   = '0;
            held_second_in = '0;
            seq_length_in  = '0;
            held_count_in  = '0;
            if (esc_v.hit) begin
               tail     = esc_v.text;
               tail_len = esc_v.len;
            end else if (seq_length_ff == 2'd2) begin
               tail[0]  = held_lead_ff;
               tail[1]  = in_byte;
               tail_len = 3'd2;
            end else begin
               tail[0]  = held_lead_ff;
               tail[1]  = held_second_ff;
               tail[2]  = in_byte;
               tail_len = 3'd3;
            end
         end else if (in_last) begin
            held_lead_in   = '0;
            held_second_in = '0;
            seq_length_in  = '0;
            held_count_in  = '0;
            tail[0]        = held_lead_ff;
            tail[1]        = in_byte;
            tail_len       = 3'd2;
         end else begin
            held_second_in = in_byte;
            held_count_in  = 2'd2;
         end
      end else begin
         if (pending) begin
            pre[0]  = held_lead_ff;
            pre[1]  = held_second_ff;
            pre_len = two_held ? 2'd2 : 2'd1;
         end
         held_lead_in   = '0;
         held_second_in = '0;
         seq_length_in  = '0;
         held_count_in  = '0;
         if (starts2 || starts3) begin
            if (in_last) begin
               tail[0]  = in_byte;
               tail_len = 3'd1;
            end else begin
               held_lead_in  = in_byte;
               seq_length_in = starts3 ? 2'd3 : 2'd2;
               held_count_in = 2'd1;
            end
         end else if (esc_b.hit) begin
            tail     = esc_b.text;
            tail_len = esc_b.len;
         end else begin
            tail[0]  = in_byte;
            tail_len = 3'd1;
         end
      end

      tidx = '0;
      for (int i = 0; i < MaxBytes; i++) begin
         tidx = LenWidth'(i) - {1'b0, pre_len};
         if (LenWidth'(i) < {1'b0, pre_len})
            pkt.bytes[i] = pre[i[0]];
         else
            pkt.bytes[i] = tail[tidx];
      end
      pkt.len  = tail_len + {1'b0, pre_len};
      pkt.last = in_last;
   end

   assign pkt_push = in_accept && (pkt.len != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_lead_ff   <= '0;
         held_second_ff <= '0;
         seq_length_ff  <= '0;
         held_count_ff  <= '0;
      end else if (in_accept) begin
         held_lead_ff   <= held_lead_in;
         held_second_ff <= held_second_in;
         seq_length_ff  <= seq_length_in;
         held_count_ff  <= held_count_in;
      end
   end

endmodule

/* rtl/jse_queue.sv */
// ----------------------------------------------------------------------------
// jse_queue: packet queue
// Small FIFO of packets that decouples the front end from the serializer.
// ----------------------------------------------------------------------------
module jse_queue
   import jse_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  pkt_type push_pkt,
   input  logic    pop,
   output pkt_type head_pkt,
   output logic    not_empty,
   output logic    not_full
);

   pkt_type                 entry_ff [QueueDepth];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]   count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign not_full  = (count_ff != CountWidth'(QueueDepth));
   assign head_pkt  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PtrWidth'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PtrWidth'(1) : rd_ptr_ff;
      count_in  = count_ff + CountWidth'(push) - CountWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         entry_ff[wr_ptr_ff] <= push_pkt;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> not_full)
      else $error("packet pushed into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("packet popped from empty queue");

   a_no_empty_pkt: assert property (@(posedge clock) disable iff (reset)
      push |-> (push_pkt.len != '0) && (push_pkt.len <= LenWidth'(MaxBytes)))
      else $error("packet length out of range");

endmodule

/* rtl/jse_back.sv */
// ----------------------------------------------------------------------------
// jse_back: byte serializer
// Sends the bytes of the head packet one per transaction and marks the
// last byte of each packet and of the string.
// ----------------------------------------------------------------------------
module jse_back
   import jse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  pkt_type    head_pkt,
   input  logic       head_valid,
   output logic       pop,
   output logic       out_valid,
   input  logic       out_ready,
   output byte_type   out_byte,
   output logic       out_run_last,
   output logic       out_end
);

   logic [LenWidth-1:0] idx_ff, idx_in;
   logic                at_end;

   assign at_end       = (idx_ff == head_pkt.len - LenWidth'(1));
   assign out_valid    = head_valid;
   assign out_byte     = head_pkt.bytes[idx_ff];
   assign out_run_last = at_end;
   assign out_end      = at_end && head_pkt.last;
   assign pop          = out_valid && out_ready && at_end;

   always_comb begin
      idx_in = idx_ff;
      if (out_valid && out_ready)
         idx_in = at_end ? '0 : idx_ff + LenWidth'(1);
   end

   always_ff @(posedge clock) begin
      if (reset)
         idx_ff <= '0;
      else
         idx_ff <= idx_in;
   end

   a_idx_in_pkt: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (idx_ff < head_pkt.len))
      else $error("byte index beyond packet length");

   a_idx_zero_idle: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> (idx_ff == '0))
      else $error("byte index not cleared with queue empty");

endmodule

/* rtl/javascript_string_escape.sv */
// ----------------------------------------------------------------------------
// javascript_string_escape: JavaScript string escaper for UTF-8 bytes
// Escapes quotes, backslash, control and markup characters and U+2028/U+2029.
// ----------------------------------------------------------------------------
// One raw byte is taken per cycle as long as the packet queue (four entries)
// has room; the front end decodes it at once and queues the 0 to 6 output
// bytes it causes, and the serializer sends one output byte per cycle while
// rsp_tready is high; each result is registered in the packet queue before
// its first byte is offered. Every output byte is its own transaction, so an
// escaped character costs as many transactions as its escape text (2 to 6).
// Lead bytes 0xC0-0xEF are held until their sequence completes, breaks, or
// the string ends (tlast), and then produce no output until that point.
module javascript_string_escape
   import jse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // is_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tuser,   // [0] run_last
   output logic       rsp_tlast    // stream_end
);

   pkt_type push_pkt, head_pkt;
   logic    push, pop, head_valid, not_full, req_accept;

   assign req_tready = not_full;
   assign req_accept = req_tvalid && req_tready;

   jse_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_accept (req_accept),
      .in_byte   (req_tdata),
      .in_last   (req_tlast),
      .pkt_push  (push),
      .pkt       (push_pkt)
   );

   jse_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_pkt  (push_pkt),
      .pop       (pop),
      .head_pkt  (head_pkt),
      .not_empty (head_valid),
      .not_full  (not_full)
   );

   jse_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_pkt     (head_pkt),
      .head_valid   (head_valid),
      .pop          (pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_byte     (rsp_tdata),
      .out_run_last (rsp_tuser),
      .out_end      (rsp_tlast)
   );

endmodule

/* verif/tb_javascript_string_escape.sv */
// ----------------------------------------------------------------------------
// tb_javascript_string_escape: self-checking bench for the string escaper
// Drives UTF-8 byte strings into the request stream and checks every escaped
// output byte, with its end-of-input and end-of-string flags, against a
// predictor kept in the bench. Directed tests cover each table entry,
// multi-byte and overlong forms, broken and truncated sequences. Random tests
// then run mostly well-formed sequences, with random idle and stall cycles.
// ----------------------------------------------------------------------------
module tb_javascript_string_escape;

   localparam int StallLimit   = 2000;
   localparam int SettleCycles = 20;

   localparam logic [12:0][7:0] EscChars = {8'h3D, 8'h3E, 8'h3C, 8'h26, 8'h0B, 8'h08,
                                            8'h0A, 8'h0D, 8'h09, 8'h5C, 8'h27, 8'h22,
                                            8'h00};

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       stream_end;
   } esc_byte_type;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [7:0] data_byte
   logic       req_tlast;   // is_last
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // [7:0] out_byte
   logic       rsp_tuser;   // [0] run_last
   logic       rsp_tlast;   // stream_end

   esc_byte_type esc_expected[$];
   logic [7:0]   char_bytes[$];
   logic [7:0]   hold_lead;
   logic [7:0]   hold_second;
   logic [1:0]   hold_len;
   logic [1:0]   hold_cnt;
   int           mismatch_count;
   int           req_gap_max;
   int           rsp_stall_max;

   javascript_string_escape u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void add_char_byte(input logic [7:0] c);
      char_bytes.insert(char_bytes.size(), c);
   endfunction

   function automatic void add_expected(input esc_byte_type r);
      esc_expected.insert(esc_expected.size(), r);
   endfunction

   function automatic string escape_text(input int unsigned cp);
      case (cp)
         32'h0000: return "\\x00";
         32'h0022: return "\\x22";
         32'h0027: return "\\x27";
         32'h005C: return "\\\\";
         32'h0009: return "\\t";
         32'h000D: return "\\r";
         32'h000A: return "\\n";
         32'h0008: return "\\b";
         32'h000B: return "\\x0b";
         32'h0026: return "\\x26";
         32'h003C: return "\\x3c";
         32'h003E: return "\\x3e";
         32'h003D: return "\\x3d";
         32'h2028: return "\\u2028";
         32'h2029: return "\\u2029";
         default:  return "";
      endcase
   endfunction

   function automatic void emit_char(input int unsigned cp, input int n,
                                     input logic [7:0] r0, input logic [7:0] r1,
                                     input logic [7:0] r2);
      string      txt;
      logic [7:0] raw[3];
      txt = escape_text(cp);
      raw[0] = r0;
      raw[1] = r1;
      raw[2] = r2;
      if (txt.len() != 0) begin
         for (int i = 0; i < txt.len(); i++) add_char_byte(txt[i]);
      end else begin
         for (int i = 0; i < n; i++) add_char_byte(raw[i]);
      end
   endfunction

   function automatic void clear_held();
      hold_lead   = '0;
      hold_second = '0;
      hold_len    = '0;
      hold_cnt    = '0;
   endfunction

   function automatic void flush_held();
      add_char_byte(hold_lead);
      if (hold_len == 2'd3 && hold_cnt == 2'd2) add_char_byte(hold_second);
      clear_held();
   endfunction

   function automatic void start_fresh(input logic [7:0] b);
      if (b[7:5] == 3'b110) begin
         hold_lead = b;
         hold_len  = 2'd2;
         hold_cnt  = 2'd1;
      end else if (b[7:4] == 4'hE) begin
         hold_lead = b;
         hold_len  = 2'd3;
         hold_cnt  = 2'd1;
      end else begin
         emit_char(32'(b), 1, b, 8'h00, 8'h00);
      end
   endfunction

   function automatic void predict_escape(input logic [7:0] b, input logic last);
      int unsigned  cp;
      logic [7:0]   lead;
      logic [7:0]   second;
      logic [1:0]   len;
      int           n;
      esc_byte_type item;
      char_bytes.delete();
      if (hold_len != 2'd0) begin
         if (b[7:6] == 2'b10) begin
            if (hold_cnt + 2'd1 == hold_len) begin
               lead   = hold_lead;
               second = hold_second;
               len    = hold_len;
               clear_held();
               if (len == 2'd2) begin
                  cp = 32'({lead[5:0], b[5:0]});
                  emit_char(cp, 2, lead, b, 8'h00);
               end else begin
                  cp = 32'({lead[4:0], second[5:0], b[5:0]});
                  emit_char(cp, 3, lead, second, b);
               end
            end else begin
               hold_second = b;
               hold_cnt    = 2'd2;
            end
         end else begin
            flush_held();
            start_fresh(b);
         end
      end else begin
         start_fresh(b);
      end
      if (last && hold_len != 2'd0) flush_held();
      n = (char_bytes.size() > 6) ? 6 : char_bytes.size();
      for (int k = 0; k < n; k++) begin
         item.out_byte   = char_bytes[k];
         item.run_last   = (k == n - 1);
         item.stream_end = (k == n - 1) && last;
         add_expected(item);
      end
   endfunction

   // ---------------------------------------------------------------- request side

   // entered at a rising edge; returns at the edge where the transaction happens
   task automatic send_byte(input logic [7:0] data, input logic last);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      predict_escape(data, last);
      @(posedge clock);
   endtask

   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (esc_expected.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_single_chars();
      for (int i = 0; i < 13; i++) send_byte(EscChars[i], (i == 12));
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   task automatic test_utf8_sequences();
      send_byte(8'hE2, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hA8, 1'b0);
      send_byte(8'hE2, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hA9, 1'b1);
      // overlong two-byte form of a double quote
      send_byte(8'hC0, 1'b0);
      send_byte(8'hA2, 1'b0);
   endtask

   task automatic test_broken_sequences();
      // two held bytes broken by NUL: raw pair plus a four-byte escape
      send_byte(8'hE2, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h00, 1'b0);
      // string ends in the middle of a three-byte sequence
      send_byte(8'hE2, 1'b0);
      send_byte(8'h80, 1'b1);
   endtask

   task automatic test_random_stream(input int n_items, input int gap_max,
                                     input int stall_max);
      logic [7:0] seq_b[4];
      logic       seq_l[4];
      logic [7:0] v;
      int         sent;
      int         n;
      int         pick;
      req_gap_max   = gap_max;
      rsp_stall_max = stall_max;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(0, 99);
         v    = EscChars[$urandom_range(0, 12)];
         for (int i = 0; i < 4; i++) seq_l[i] = ($urandom_range(0, 9) == 0);
         if (pick < 30) begin
            if ($urandom_range(0, 1)) seq_b[0] = v;
            else seq_b[0] = 8'($urandom_range(0, 127));
            n = 1;
         end else if (pick < 50) begin
            if ($urandom_range(0, 2) == 0) begin
               seq_b[0] = {6'b110000, v[7:6]};
               seq_b[1] = {2'b10, v[5:0]};
            end else begin
               seq_b[0] = 8'($urandom_range(8'hC0, 8'hDF));
               seq_b[1] = 8'($urandom_range(8'h80, 8'hBF));
            end
            n = 2;
         end else if (pick < 70) begin
            case ($urandom_range(0, 5))
               0, 1: begin
                  seq_b[0] = 8'hE2;
                  seq_b[1] = 8'h80;
                  seq_b[2] = {7'b1010100, 1'($urandom_range(0, 1))};
               end
               2: begin
                  seq_b[0] = 8'hE0;
                  seq_b[1] = {6'b100000, v[7:6]};
                  seq_b[2] = {2'b10, v[5:0]};
               end
               default: begin
                  seq_b[0] = 8'($urandom_range(8'hE0, 8'hEF));
                  seq_b[1] = 8'($urandom_range(8'h80, 8'hBF));
                  seq_b[2] = 8'($urandom_range(8'h80, 8'hBF));
               end
            endcase
            n = 3;
         end else if (pick < 85) begin
            seq_b[0] = 8'($urandom_range(8'hC0, 8'hEF));
            n = 1;
            if (seq_b[0][7:4] == 4'hE && $urandom_range(0, 1)) begin
               seq_b[1] = 8'($urandom_range(8'h80, 8'hBF));
               n = 2;
            end
            if ($urandom_range(0, 1)) begin
               seq_l[n-1] = 1'b1;
            end else begin
               if ($urandom_range(0, 1)) seq_b[n] = 8'($urandom_range(0, 127));
               else seq_b[n] = 8'($urandom_range(8'hC0, 8'hFF));
               n++;
            end
         end else begin
            seq_b[0] = 8'($urandom_range(0, 255));
            n = 1;
         end
         for (int i = 0; i < n; i++) send_byte(seq_b[i], seq_l[i]);
         sent += n;
      end
   endtask

   // ---------------------------------------------------------------- response side

   task automatic report_mismatch(input string what, input esc_byte_type exp_r,
                                  input esc_byte_type got_r);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%s: out_byte exp %h got %h, run_last exp %b got %b, stream_end exp %b got %b",
                  what, exp_r.out_byte, got_r.out_byte, exp_r.run_last, got_r.run_last,
                  exp_r.stream_end, got_r.stream_end);
   endtask

   initial begin : rsp_checker
      esc_byte_type got_r;
      esc_byte_type exp_r;
      logic         got;
      int           stall;
      rsp_tready <= 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         stall = $urandom_range(0, rsp_stall_max);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do begin
            @(negedge clock);
            got              = (rsp_tvalid === 1'b1);
            got_r.out_byte   = rsp_tdata;
            got_r.run_last   = rsp_tuser;
            got_r.stream_end = rsp_tlast;
            @(posedge clock);
         end while (!got);
         if (esc_expected.size() == 0) begin
            report_mismatch("unexpected transaction", '0, got_r);
         end else begin
            exp_r = esc_expected.pop_front();
            if (got_r.out_byte !== exp_r.out_byte || got_r.run_last !== exp_r.run_last ||
                got_r.stream_end !== exp_r.stream_end)
               report_mismatch("mismatch", exp_r, got_r);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < StallLimit) begin
         @(negedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("timeout: no transaction for %0d cycles", StallLimit);
      $display("== FAIL ==");
      $finish;
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      mismatch_count = 0;
      req_gap_max    = 4;
      rsp_stall_max  = 4;
      clear_held();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_single_chars();
      test_utf8_sequences();
      test_broken_sequences();
      wait_results_drained();

      test_random_stream(95, 12, 12);
      wait_results_drained();
      test_random_stream(110, 0, 0);
      test_random_stream(70, 0, 12);
      wait_results_drained();
      test_random_stream(70, 12, 0);

      wait_results_drained();
      repeat (SettleCycles) @(posedge clock);
      if (esc_expected.size() != 0) begin
         mismatch_count += esc_expected.size();
         $display("%0d expected results never arrived", esc_expected.size());
      end
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/jse_pkg.sv
rtl/jse_front.sv
rtl/jse_queue.sv
rtl/jse_back.sv
rtl/javascript_string_escape.sv
verif/tb_javascript_string_escape.sv
